FILE: sv/rrf_pkg.sv
// Shared widths, payload structs and rounding and saturation helpers for the ray refraction block.
// No dependencies; every other file in this folder imports it.
package rrf_pkg;

   localparam int DIR_FRAC   = 14;
   localparam int DIR_W      = DIR_FRAC + 2;
   localparam int DIR_ONE    = 1 << DIR_FRAC;
   localparam int SLOPE_W    = 24;
   localparam int SLOPE_FRAC = SLOPE_W - 8;
   localparam int IDX_W      = 16;
   localparam int TAN_BITS   = 30;
   localparam int FRES_BITS  = 31;
   localparam int REFL_W     = 17;
   localparam int REFL_ONE   = 1 << (REFL_W - 1);

   // Side band carried beside each iterative unit.
   localparam int SIDE_W     = 160;

   // Square root unit: radicand and root widths.
   localparam int SQ_RAD_W   = 48;
   localparam int SQ_ROOT_W  = SQ_RAD_W / 2;

   // Divider unit: dividend, divisor and quotient widths.
   localparam int DV_DEN_W   = 32;
   localparam int DV_Q_W     = 32;
   localparam int DV_NUM_W   = DV_DEN_W + DV_Q_W;

   typedef struct packed {
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [SLOPE_W-1:0] surface_slope;
      logic [IDX_W-1:0]          index_from;
      logic [IDX_W-1:0]          index_to;
   } req_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] new_dir_x;
      logic signed [DIR_W-1:0] new_dir_y;
      logic [REFL_W-1:0]       reflectance;
      logic                    total_reflection;
   } rsp_type;

   // Divide by 2^TAN_BITS, rounding half away from zero.
   function automatic logic signed [63:0] rnd_tan(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'(1) << (TAN_BITS - 1))) >> TAN_BITS;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   // Limit a direction component to [-1, 1].
   function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [18:0] v);
      logic signed [18:0] lim;
      lim = 19'(DIR_ONE);
      if (v > lim) begin
         return DIR_W'(lim);
      end else if (v < -lim) begin
         return DIR_W'(-lim);
      end
      return DIR_W'(v);
   endfunction

endpackage

FILE: sv/rrf_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side band.
// Depends on rrf_pkg for widths.
module rrf_sqrt import rrf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [SQ_RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [SQ_ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int N  = SQ_ROOT_W;
   localparam int RW = SQ_ROOT_W + 4;

   logic                 v_ff    [0:N];
   logic [SQ_RAD_W-1:0]  rad_ff  [0:N];
   logic [RW-1:0]        rem_ff  [0:N];
   logic [SQ_ROOT_W-1:0] root_ff [0:N];
   logic [SIDE_W-1:0]    side_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      localparam int I = N - k;
      logic [RW-1:0] t_in;
      logic [RW-1:0] trial_in;
      logic          ge_in;

      always_comb begin
         t_in     = {rem_ff[k-1][RW-3:0], rad_ff[k-1][2*I+1 -: 2]};
         trial_in = RW'({root_ff[k-1], 2'b01});
         ge_in    = (t_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_ff[k-1];
            rem_ff[k]  <= ge_in ? (t_in - trial_in) : t_in;
            root_ff[k] <= {root_ff[k-1][SQ_ROOT_W-2:0], ge_in};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_root  = root_ff[N];
   assign out_side  = side_ff[N];

endmodule

FILE: sv/rrf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side band.
// Depends on rrf_pkg for widths; the quotient must fit DV_Q_W bits to be exact.
module rrf_div import rrf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DV_NUM_W-1:0] in_num,
   input  logic [DV_DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [DV_Q_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int N = DV_Q_W;

   logic                v_ff    [0:N];
   logic [DV_NUM_W-1:0] num_ff  [0:N];
   logic [DV_DEN_W-1:0] den_ff  [0:N];
   logic [DV_DEN_W-1:0] rem_ff  [0:N];
   logic [DV_Q_W-1:0]   quot_ff [0:N];
   logic [SIDE_W-1:0]   side_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= in_num[DV_NUM_W-1 -: DV_DEN_W];
         quot_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      localparam int I = N - k;
      logic [DV_DEN_W:0] t_in;
      logic [DV_DEN_W:0] diff_in;
      logic              ge_in;

      always_comb begin
         t_in    = {rem_ff[k-1], num_ff[k-1][I]};
         diff_in = t_in - {1'b0, den_ff[k-1]};
         ge_in   = (t_in >= {1'b0, den_ff[k-1]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k]  <= num_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            rem_ff[k]  <= ge_in ? diff_in[DV_DEN_W-1:0] : t_in[DV_DEN_W-1:0];
            quot_ff[k] <= {quot_ff[k-1][DV_Q_W-2:0], ge_in};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_quot  = quot_ff[N];
   assign out_side  = side_ff[N];

endmodule

FILE: sv/ray_refraction_fresnel.sv
// Top level: 2-D refraction at a sloped surface with Fresnel power reflectance.
// Depends on rrf_pkg, rrf_sqrt and rrf_div.
//
//   Channel  Direction  Ports                                     Beat carries
//   req      in         req_valid, req_ready, req_data            one ray (req_type)
//   rsp      out        rsp_valid, rsp_ready, rsp_data            one result (rsp_type)
//   csr      in         csr_valid, csr_ready, csr_polarisation_mode  polarization select
//
// The pipeline takes one ray per cycle while it is not held. Its depth is set by three
// square root units (25 stages each, one root bit per stage) and three divider rows
// (33 stages each, one quotient bit per stage) in series, plus stage 0, the multiply
// and rounding stages P1, P2, Q1, R1, R2, R3, F1 and the output register.
// All stages advance together: when a result waits at the output and rsp_ready
// is low, the whole pipeline holds, and req_ready is low until it moves again.
// Synchronous reset clears every valid bit and sets the polarization mode to one.
module ray_refraction_fresnel import rrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_polarisation_mode
);

   // Side band layouts for the stretches between iterative units.
   typedef struct packed {
      logic signed [DIR_W-1:0] vx;
      logic signed [DIR_W-1:0] vy;
      logic                    neg;
      logic [SLOPE_W-1:0]      b;
      logic [IDX_W-1:0]        n1;
      logic [IDX_W-1:0]        n2;
      logic                    mode;
   } seg_a_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] vx;
      logic signed [DIR_W-1:0] vy;
      logic                    neg;
      logic [IDX_W-1:0]        n1;
      logic [IDX_W-1:0]        n2;
      logic                    mode;
   } seg_b_type;

   typedef struct packed {
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [17:0] proj;
      logic signed [17:0] nl;
      logic               psign;
      logic [IDX_W-1:0]   n1;
      logic [IDX_W-1:0]   n2;
      logic               mode;
      logic               tir;
   } seg_c_type;

   typedef struct packed {
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [17:0] proj;
      logic signed [17:0] nl;
      logic signed [16:0] tl;
      logic [IDX_W-1:0]   n1;
      logic [IDX_W-1:0]   n2;
      logic               mode;
      logic               tir;
   } seg_d_type;

   typedef struct packed {
      logic signed [17:0] u;
      logic signed [17:0] w;
      logic               tir;
      logic [30:0]        fn;
      logic [30:0]        fd;
      logic               dz;
   } seg_e_type;

   typedef struct packed {
      logic signed [17:0] u;
      logic signed [17:0] w;
      logic               tir;
      logic               rz;
      logic               dz;
   } seg_f_type;

   localparam logic [SQ_RAD_W-1:0] RAD_SLOPE_ONE = SQ_RAD_W'(1) << (2 * SLOPE_FRAC);
   localparam logic [SQ_RAD_W-1:0] RAD_DIR_ONE   = SQ_RAD_W'(1) << (2 * DIR_FRAC);
   localparam logic [DV_NUM_W-1:0] TX_NUM        = DV_NUM_W'(1) << (SLOPE_FRAC + TAN_BITS);

   // Global advance: every stage moves unless a finished result is stuck.
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic mode_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_polarisation_mode;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 0: register the ray, take the slope magnitude, clamp a zero index_to to one.
   // ---------------------------------------------------------------------------
   logic      v0_ff;
   seg_a_type a0_ff;
   seg_a_type a0_in;

   always_comb begin
      a0_in.vx   = req_data.dir_x;
      a0_in.vy   = req_data.dir_y;
      a0_in.neg  = req_data.surface_slope[SLOPE_W-1];
      a0_in.b    = a0_in.neg ? SLOPE_W'(-req_data.surface_slope)
                             : SLOPE_W'(req_data.surface_slope);
      a0_in.n1   = req_data.index_from;
      a0_in.n2   = (req_data.index_to == '0) ? IDX_W'(1) : req_data.index_to;
      a0_in.mode = mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff <= a0_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Length of the unscaled tangent (1, slope) in slope units.
   // ---------------------------------------------------------------------------
   logic                 l_valid;
   logic [SQ_ROOT_W-1:0] l_root;
   logic [SIDE_W-1:0]    l_side;
   seg_a_type            a_l;

   rrf_sqrt u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v0_ff),
      .in_rad    (SQ_RAD_W'(a0_ff.b) * SQ_RAD_W'(a0_ff.b) + RAD_SLOPE_ONE),
      .in_side   (SIDE_W'(a0_ff)),
      .out_valid (l_valid),
      .out_root  (l_root),
      .out_side  (l_side)
   );

   assign a_l = seg_a_type'(l_side[$bits(seg_a_type)-1:0]);

   // Unit tangent in Q1.30: both components are rounded quotients by the length.
   logic [DV_NUM_W-1:0] tx_num_in;
   logic [DV_NUM_W-1:0] ty_num_in;
   seg_b_type           b_in;

   always_comb begin
      tx_num_in = TX_NUM + DV_NUM_W'(l_root >> 1);
      ty_num_in = (DV_NUM_W'(a_l.b) << TAN_BITS) + DV_NUM_W'(l_root >> 1);
      b_in.vx   = a_l.vx;
      b_in.vy   = a_l.vy;
      b_in.neg  = a_l.neg;
      b_in.n1   = a_l.n1;
      b_in.n2   = a_l.n2;
      b_in.mode = a_l.mode;
   end

   logic              t_valid;
   logic [DV_Q_W-1:0] q_tx;
   logic [DV_Q_W-1:0] q_ty;
   logic [SIDE_W-1:0] t_side;
   seg_b_type         b_t;

   rrf_div u_div_tx (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (l_valid),
      .in_num    (tx_num_in),
      .in_den    (DV_DEN_W'(l_root)),
      .in_side   (SIDE_W'(b_in)),
      .out_valid (t_valid),
      .out_quot  (q_tx),
      .out_side  (t_side)
   );

   rrf_div u_div_ty (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (l_valid),
      .in_num    (ty_num_in),
      .in_den    (DV_DEN_W'(l_root)),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (q_ty),
      .out_side  ()
   );

   assign b_t = seg_b_type'(t_side[$bits(seg_b_type)-1:0]);

   // ---------------------------------------------------------------------------
   // P1: products of the ray with the tangent. P2: projections, rounded.
   // ---------------------------------------------------------------------------
   logic               p1_v_ff;
   logic signed [31:0] tx_in, ty_in;
   logic signed [31:0] p1_tx_ff, p1_ty_ff;
   logic signed [47:0] p1_ma_ff, p1_mb_ff, p1_mc_ff, p1_md_ff;
   logic [IDX_W-1:0]   p1_n1_ff, p1_n2_ff;
   logic               p1_mode_ff;

   always_comb begin
      tx_in = $signed({1'b0, q_tx[30:0]});
      ty_in = b_t.neg ? -$signed({1'b0, q_ty[30:0]}) : $signed({1'b0, q_ty[30:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= t_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_tx_ff   <= tx_in;
         p1_ty_ff   <= ty_in;
         p1_ma_ff   <= 48'(b_t.vx) * 48'(tx_in);
         p1_mb_ff   <= 48'(b_t.vy) * 48'(ty_in);
         p1_mc_ff   <= 48'(b_t.vy) * 48'(tx_in);
         p1_md_ff   <= 48'(b_t.vx) * 48'(ty_in);
         p1_n1_ff   <= b_t.n1;
         p1_n2_ff   <= b_t.n2;
         p1_mode_ff <= b_t.mode;
      end
   end

   logic               p2_v_ff;
   logic signed [31:0] p2_tx_ff, p2_ty_ff;
   logic signed [17:0] p2_proj_ff, p2_nl_ff;
   logic [IDX_W-1:0]   p2_n1_ff, p2_n2_ff;
   logic               p2_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (adv) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_tx_ff   <= p1_tx_ff;
         p2_ty_ff   <= p1_ty_ff;
         p2_proj_ff <= 18'(rnd_tan(64'(p1_ma_ff) + 64'(p1_mb_ff)));
         p2_nl_ff   <= 18'(rnd_tan(64'(p1_mc_ff) - 64'(p1_md_ff)));
         p2_n1_ff   <= p1_n1_ff;
         p2_n2_ff   <= p1_n2_ff;
         p2_mode_ff <= p1_mode_ff;
      end
   end

   // Total reflection test and the scaled tangential part tl = proj * n1 / n2.
   logic [16:0]         pm_in;
   logic [32:0]         pn_in;
   logic [DV_NUM_W-1:0] tl_num_in;
   seg_c_type           c_in;

   always_comb begin
      pm_in       = p2_proj_ff[17] ? 17'(-p2_proj_ff) : 17'(p2_proj_ff);
      pn_in       = 33'(pm_in) * 33'(p2_n1_ff);
      tl_num_in   = DV_NUM_W'(pn_in) + DV_NUM_W'(p2_n2_ff >> 1);
      c_in.tx     = p2_tx_ff;
      c_in.ty     = p2_ty_ff;
      c_in.proj   = p2_proj_ff;
      c_in.nl     = p2_nl_ff;
      c_in.psign  = p2_proj_ff[17];
      c_in.n1     = p2_n1_ff;
      c_in.n2     = p2_n2_ff;
      c_in.mode   = p2_mode_ff;
      c_in.tir    = ({1'b0, pn_in} > (34'(p2_n2_ff) << DIR_FRAC));
   end

   logic              tl_valid;
   logic [DV_Q_W-1:0] q_tl;
   logic [SIDE_W-1:0] tl_side;
   seg_c_type         c_t;

   rrf_div u_div_tl (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p2_v_ff),
      .in_num    (tl_num_in),
      .in_den    (DV_DEN_W'(p2_n2_ff)),
      .in_side   (SIDE_W'(c_in)),
      .out_valid (tl_valid),
      .out_quot  (q_tl),
      .out_side  (tl_side)
   );

   assign c_t = seg_c_type'(tl_side[$bits(seg_c_type)-1:0]);

   // ---------------------------------------------------------------------------
   // Q1: sign the tangential part and square it for the normal part c1.
   // Outside total reflection |tl| never exceeds one, so 16 bits hold it.
   // ---------------------------------------------------------------------------
   logic        q1_v_ff;
   seg_d_type   q1_d_ff;
   logic [31:0] q1_tlsq_ff;
   seg_d_type   d_in;

   always_comb begin
      d_in.tx   = c_t.tx;
      d_in.ty   = c_t.ty;
      d_in.proj = c_t.proj;
      d_in.nl   = c_t.nl;
      d_in.tl   = c_t.psign ? -$signed({1'b0, q_tl[15:0]}) : $signed({1'b0, q_tl[15:0]});
      d_in.n1   = c_t.n1;
      d_in.n2   = c_t.n2;
      d_in.mode = c_t.mode;
      d_in.tir  = c_t.tir;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_v_ff <= 1'b0;
      end else if (adv) begin
         q1_v_ff <= tl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_d_ff    <= d_in;
         q1_tlsq_ff <= 32'(q_tl[15:0]) * 32'(q_tl[15:0]);
      end
   end

   logic                 c1_valid;
   logic [SQ_ROOT_W-1:0] c1_root;
   logic [SIDE_W-1:0]    c1_side;
   seg_d_type            d_c;

   rrf_sqrt u_sqrt_c1 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (q1_v_ff),
      .in_rad    (RAD_DIR_ONE - SQ_RAD_W'(q1_tlsq_ff)),
      .in_side   (SIDE_W'(q1_d_ff)),
      .out_valid (c1_valid),
      .out_root  (c1_root),
      .out_side  (c1_side)
   );

   assign d_c = seg_d_type'(c1_side[$bits(seg_d_type)-1:0]);

   // ---------------------------------------------------------------------------
   // R1: rotate back to world axes. Total reflection rotates (proj, nl) and
   // refraction rotates (tl, nn) with the same products, so one set serves both.
   // The Fresnel products n1*c0, n2*c1 (or the swapped pair) are formed here too.
   // A zero normal component counts as positive, which gives nn = -c1.
   // ---------------------------------------------------------------------------
   logic [15:0]        c1_in;
   logic [16:0]        c0_in;
   logic signed [16:0] nn_in;
   logic signed [17:0] av_in, bv_in;
   logic [16:0]        fx_in, fy_in;

   always_comb begin
      c1_in = c1_root[15:0];
      c0_in = d_c.nl[17] ? 17'(-d_c.nl) : 17'(d_c.nl);
      nn_in = d_c.nl[17] ? $signed({1'b0, c1_in}) : -$signed({1'b0, c1_in});
      av_in = d_c.tir ? d_c.proj : 18'(d_c.tl);
      bv_in = d_c.tir ? d_c.nl : 18'(nn_in);
      fx_in = d_c.mode ? c0_in : 17'(c1_in);
      fy_in = d_c.mode ? 17'(c1_in) : c0_in;
   end

   logic               r1_v_ff;
   logic signed [49:0] r1_ma_ff, r1_mb_ff, r1_mc_ff, r1_md_ff;
   logic [32:0]        r1_p_ff, r1_q_ff;
   logic               r1_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_v_ff <= 1'b0;
      end else if (adv) begin
         r1_v_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ma_ff  <= 50'(av_in) * 50'(d_c.tx);
         r1_mb_ff  <= 50'(bv_in) * 50'(d_c.ty);
         r1_mc_ff  <= 50'(av_in) * 50'(d_c.ty);
         r1_md_ff  <= 50'(bv_in) * 50'(d_c.tx);
         r1_p_ff   <= 33'(d_c.n1) * 33'(fx_in);
         r1_q_ff   <= 33'(d_c.n2) * 33'(fy_in);
         r1_tir_ff <= d_c.tir;
      end
   end

   // R2: rounded direction before renormalizing, Fresnel numerator and denominator.
   logic               r2_v_ff;
   logic signed [17:0] r2_u_ff, r2_w_ff;
   logic [32:0]        r2_fnum_ff;
   logic [33:0]        r2_fden_ff;
   logic               r2_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_v_ff <= 1'b0;
      end else if (adv) begin
         r2_v_ff <= r1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_u_ff    <= 18'(rnd_tan(64'(r1_ma_ff) + 64'(r1_mb_ff)));
         r2_w_ff    <= 18'(rnd_tan(64'(r1_mc_ff) - 64'(r1_md_ff)));
         r2_fnum_ff <= (r1_p_ff > r1_q_ff) ? (r1_p_ff - r1_q_ff) : (r1_q_ff - r1_p_ff);
         r2_fden_ff <= 34'(r1_p_ff) + 34'(r1_q_ff);
         r2_tir_ff  <= r1_tir_ff;
      end
   end

   // R3: squared length, and the Fresnel pair scaled below 2^31 together.
   logic [17:0] um_in, wm_in;
   logic [1:0]  fsh_in;
   seg_e_type   e_in;

   always_comb begin
      um_in = r2_u_ff[17] ? 18'(-r2_u_ff) : 18'(r2_u_ff);
      wm_in = r2_w_ff[17] ? 18'(-r2_w_ff) : 18'(r2_w_ff);
      if (r2_fden_ff[33]) begin
         fsh_in = 2'd3;
      end else if (r2_fden_ff[32]) begin
         fsh_in = 2'd2;
      end else if (r2_fden_ff[31]) begin
         fsh_in = 2'd1;
      end else begin
         fsh_in = 2'd0;
      end
      e_in.u   = r2_u_ff;
      e_in.w   = r2_w_ff;
      e_in.tir = r2_tir_ff;
      e_in.fn  = 31'(34'(r2_fnum_ff) >> fsh_in);
      e_in.fd  = 31'(r2_fden_ff >> fsh_in);
      e_in.dz  = (r2_fden_ff == '0);
   end

   logic        r3_v_ff;
   seg_e_type   r3_e_ff;
   logic [35:0] r3_usq_ff, r3_wsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r3_v_ff <= 1'b0;
      end else if (adv) begin
         r3_v_ff <= r2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r3_e_ff   <= e_in;
         r3_usq_ff <= 36'(um_in) * 36'(um_in);
         r3_wsq_ff <= 36'(wm_in) * 36'(wm_in);
      end
   end

   logic                 r_valid;
   logic [SQ_ROOT_W-1:0] r_root;
   logic [SIDE_W-1:0]    r_side;
   seg_e_type            e_r;

   rrf_sqrt u_sqrt_r (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r3_v_ff),
      .in_rad    (SQ_RAD_W'(r3_usq_ff) + SQ_RAD_W'(r3_wsq_ff)),
      .in_side   (SIDE_W'(r3_e_ff)),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   assign e_r = seg_e_type'(r_side[$bits(seg_e_type)-1:0]);

   // ---------------------------------------------------------------------------
   // Renormalize to unit length and form the Fresnel ratio, three dividers abreast.
   // A zero length or zero Fresnel denominator divides by one; the flag rides along.
   // ---------------------------------------------------------------------------
   logic [17:0]         ue_in, we_in;
   logic                rz_in;
   logic [DV_DEN_W-1:0] rden_in;
   logic [DV_NUM_W-1:0] ox_num_in, oy_num_in, fr_num_in;
   logic [DV_DEN_W-1:0] fr_den_in;
   seg_f_type           f_in;

   always_comb begin
      ue_in     = e_r.u[17] ? 18'(-e_r.u) : 18'(e_r.u);
      we_in     = e_r.w[17] ? 18'(-e_r.w) : 18'(e_r.w);
      rz_in     = (r_root == '0);
      rden_in   = rz_in ? DV_DEN_W'(1) : DV_DEN_W'(r_root);
      ox_num_in = (DV_NUM_W'(ue_in) << DIR_FRAC) + DV_NUM_W'(r_root >> 1);
      oy_num_in = (DV_NUM_W'(we_in) << DIR_FRAC) + DV_NUM_W'(r_root >> 1);
      fr_num_in = DV_NUM_W'(e_r.fn) << FRES_BITS;
      fr_den_in = e_r.dz ? DV_DEN_W'(1) : DV_DEN_W'(e_r.fd);
      f_in.u    = e_r.u;
      f_in.w    = e_r.w;
      f_in.tir  = e_r.tir;
      f_in.rz   = rz_in;
      f_in.dz   = e_r.dz;
   end

   logic              o_valid;
   logic [DV_Q_W-1:0] q_ox, q_oy, q_fr;
   logic [SIDE_W-1:0] o_side;
   seg_f_type         f_o;

   rrf_div u_div_ox (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r_valid),
      .in_num    (ox_num_in),
      .in_den    (rden_in),
      .in_side   (SIDE_W'(f_in)),
      .out_valid (o_valid),
      .out_quot  (q_ox),
      .out_side  (o_side)
   );

   rrf_div u_div_oy (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r_valid),
      .in_num    (oy_num_in),
      .in_den    (rden_in),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (q_oy),
      .out_side  ()
   );

   rrf_div u_div_fr (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r_valid),
      .in_num    (fr_num_in),
      .in_den    (fr_den_in),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (q_fr),
      .out_side  ()
   );

   assign f_o = seg_f_type'(o_side[$bits(seg_f_type)-1:0]);

   // F1: pick the direction source, square the Fresnel amplitude ratio.
   logic signed [18:0] oxq_in, oyq_in, ox_in, oy_in;

   always_comb begin
      oxq_in = $signed({1'b0, q_ox[17:0]});
      oyq_in = $signed({1'b0, q_oy[17:0]});
      if (f_o.tir) begin
         ox_in = 19'(f_o.u);
         oy_in = 19'(f_o.w);
      end else if (f_o.rz) begin
         ox_in = '0;
         oy_in = '0;
      end else begin
         ox_in = f_o.u[17] ? -oxq_in : oxq_in;
         oy_in = f_o.w[17] ? -oyq_in : oyq_in;
      end
   end

   logic               f1_v_ff;
   logic signed [18:0] f1_ox_ff, f1_oy_ff;
   logic [63:0]        f1_qsq_ff;
   logic               f1_tir_ff, f1_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= o_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ox_ff  <= ox_in;
         f1_oy_ff  <= oy_in;
         f1_qsq_ff <= 64'(q_fr) * 64'(q_fr);
         f1_tir_ff <= f_o.tir;
         f1_dz_ff  <= f_o.dz;
      end
   end

   // Output register: saturate the direction, round the reflectance to Q1.16.
   rsp_type rsp_in;

   always_comb begin
      rsp_in.new_dir_x        = sat_dir(f1_ox_ff);
      rsp_in.new_dir_y        = sat_dir(f1_oy_ff);
      rsp_in.total_reflection = f1_tir_ff;
      if (f1_tir_ff || f1_dz_ff) begin
         rsp_in.reflectance = REFL_W'(REFL_ONE);
      end else begin
         rsp_in.reflectance = REFL_W'((f1_qsq_ff + (64'(1) << (2 * FRES_BITS - 17)))
                                      >> (2 * FRES_BITS - 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule
